@@ hw/rtl/interval_reservation_table_assert.svh @@
// ----------------------------------------------------------------------------
// Interval reservation table: assertion macros
// Concurrent checks clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_RESERVATION_TABLE_ASSERT_SVH
`define INTERVAL_RESERVATION_TABLE_ASSERT_SVH

// same-cycle implication
`define IRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/irt_pkg.sv @@
// ----------------------------------------------------------------------------
// Interval reservation table package
// Opcodes, status codes and item layouts shared by the block and its channels.
// ----------------------------------------------------------------------------
package irt_pkg;

  localparam int CycleW = 48;
  localparam int DurW   = 32;

  typedef enum logic [1:0] {
    OP_LOCK  = 2'd0,
    OP_CHECK = 2'd1,
    OP_NEXT  = 2'd2,
    OP_NOP   = 2'd3
  } irt_op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_FULL     = 2'd2
  } irt_status_e;

  typedef struct packed {
    irt_op_e             opcode;
    logic [CycleW-1:0]   start_cycle;
    logic [CycleW-1:0]   end_cycle;
    logic [DurW-1:0]     duration;
  } irt_req_t;

  typedef struct packed {
    irt_status_e         status;
    logic                is_free;
    logic [CycleW-1:0]   ready_cycle;
  } irt_rsp_t;

  // one table entry as stored: start, exclusive end
  typedef struct packed {
    logic [CycleW-1:0]   start_cycle;
    logic [CycleW-1:0]   end_cycle;
  } irt_entry_t;

endpackage

@@ hw/rtl/irt_stream_if.sv @@
// ----------------------------------------------------------------------------
// Interval reservation table stream channel
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface irt_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/interval_reservation_table.sv @@
// ----------------------------------------------------------------------------
// Interval reservation table
// Start-sorted table of half-open busy intervals with lock, check and
// next-ready search, kept in a single-port-read/single-port-write memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_i (irt_req_t) carries one operation per item: lock, check, next-ready.
//   rsp_o (irt_rsp_t) returns exactly one item per request, in order.
//   Items are processed one at a time. The table memory is read one entry per
//   cycle through a registered read port (rdata_q).
//   Check and next-ready: one read pass over the held entries; next-ready
//   may stop its pass early once a slot fits.
//   Lock: the overlap scan, then when stored a shift pass and one write.
//   A conflicting or dropped lock returns after the scan.
//   Unused opcode: skips the table pass and returns an OK status.
//   The result sits in an output register; the next request is accepted once
//   the previous result has moved into it, even while rsp_o is stalled. A
//   finished result waits for the output register to free up.
//   Reset empties the table (entry count to zero); no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "interval_reservation_table_assert.svh"

module interval_reservation_table
  import irt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  irt_stream_if.sink   req_i,
  irt_stream_if.source rsp_o
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_INS,
    S_FIN
  } state_e;

  state_e            state_q, state_d;
  irt_op_e           op_q, op_d;
  logic [CycleW-1:0] s_q, s_d;
  logic [CycleW-1:0] e_q, e_d;
  logic [CycleW-1:0] b_q, b_d;      // tested range upper bound, end - 1
  logic [DurW-1:0]   t_q, t_d;
  logic [CycleW-1:0] c_q, c_d;      // next-ready candidate cycle
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     iss_q, iss_d;  // read issue counter
  logic [CW-1:0]     p_q, p_d;      // insertion point
  logic              pfound_q, pfound_d;
  logic              ovl_q, ovl_d;
  logic              done_q, done_d;
  logic              rd_vld_q, rd_vld_d;
  logic [AW-1:0]     rd_idx_q, rd_idx_d;
  irt_rsp_t          res_q, res_d;
  logic              out_vld_q, out_vld_d;
  irt_rsp_t          out_q, out_d;

  // table memory
  irt_entry_t        mem_q [TABLE_ENTRIES];
  irt_entry_t        rdata_q;
  logic              mem_re, mem_we;
  logic [AW-1:0]     mem_raddr, mem_waddr;
  irt_entry_t        mem_wdata;

  logic              full;
  logic              issue;
  logic [CW-1:0]     iss_m1;
  logic [CycleW-1:0] ent_y;
  logic              hit;
  logic [CycleW:0]   fit_sum;

  assign full   = (cnt_q == CW'(TABLE_ENTRIES));
  assign iss_m1 = iss_q - CW'(1);

  // overlap of [s, b] against the held closed range [start, end - 1]
  always_comb begin
    logic held_in, tested_in, partial;
    ent_y     = rdata_q.end_cycle - CycleW'(1);
    held_in   = (s_q <= rdata_q.start_cycle) && (b_q >= ent_y);
    tested_in = (s_q >= rdata_q.start_cycle) && (b_q <= ent_y);
    partial   = ((s_q >= rdata_q.start_cycle) && (s_q <= ent_y)) ||
                ((b_q >= rdata_q.start_cycle) && (b_q <= ent_y));
    hit       = held_in || tested_in || partial;
  end

  assign fit_sum = {1'b0, c_q} + {{(CycleW + 1 - DurW){1'b0}}, t_q};

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    s_d       = s_q;
    e_d       = e_q;
    b_d       = b_q;
    t_d       = t_q;
    c_d       = c_q;
    cnt_d     = cnt_q;
    iss_d     = iss_q;
    p_d       = p_q;
    pfound_d  = pfound_q;
    ovl_d     = ovl_q;
    done_d    = done_q;
    rd_vld_d  = 1'b0;
    rd_idx_d  = rd_idx_q;
    res_d     = res_q;
    out_vld_d = out_vld_q && !rsp_o.ready;
    out_d     = out_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_raddr = iss_q[AW-1:0];
    mem_waddr = '0;
    mem_wdata = rdata_q;
    issue     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d     = req_i.data.opcode;
          s_d      = req_i.data.start_cycle;
          e_d      = req_i.data.end_cycle;
          b_d      = req_i.data.end_cycle - CycleW'(1);
          t_d      = req_i.data.duration;
          c_d      = req_i.data.start_cycle;
          ovl_d    = 1'b0;
          pfound_d = 1'b0;
          p_d      = cnt_q;
          done_d   = 1'b0;
          iss_d    = '0;
          res_d    = '{status: ST_OK, is_free: 1'b0, ready_cycle: '0};
          state_d  = (req_i.data.opcode == OP_NOP) ? S_FIN : S_SCAN;
        end
      end

      S_SCAN: begin
        issue = (iss_q < cnt_q) && !((op_q == OP_NEXT) && done_q);
        if (issue) begin
          mem_re    = 1'b1;
          mem_raddr = iss_q[AW-1:0];
          rd_vld_d  = 1'b1;
          rd_idx_d  = iss_q[AW-1:0];
          iss_d     = iss_q + CW'(1);
        end
        if (rd_vld_q) begin
          if (op_q == OP_NEXT) begin
            if (!done_q && !(rdata_q.end_cycle < c_q)) begin
              if (fit_sum <= {1'b0, rdata_q.start_cycle}) begin
                done_d = 1'b1;
              end else begin
                c_d = rdata_q.end_cycle;
              end
            end
          end else begin
            if (hit) begin
              ovl_d = 1'b1;
            end
            if (!pfound_q && (s_q < rdata_q.start_cycle)) begin
              pfound_d = 1'b1;
              p_d      = CW'(rd_idx_q);
            end
          end
        end
        if (!rd_vld_q && !issue) begin
          case (op_q)
            OP_CHECK: begin
              res_d.is_free = !ovl_q;
              state_d       = S_FIN;
            end
            OP_NEXT: begin
              res_d.ready_cycle = c_q;
              state_d           = S_FIN;
            end
            OP_LOCK: begin
              if (ovl_q) begin
                res_d.status = ST_CONFLICT;
                state_d      = S_FIN;
              end else begin
                res_d.is_free = 1'b1;
                if (full && (p_q == '0)) begin
                  res_d.status = ST_FULL;
                  state_d      = S_FIN;
                end else begin
                  // full: move entries 1..p-1 down; else move p..n-1 up
                  iss_d   = full ? CW'(1) : cnt_q;
                  state_d = S_SHIFT;
                end
              end
            end
            default: state_d = S_FIN;
          endcase
        end
      end

      S_SHIFT: begin
        if (full) begin
          issue = (iss_q < p_q);
          if (issue) begin
            mem_re    = 1'b1;
            mem_raddr = iss_q[AW-1:0];
            rd_idx_d  = iss_q[AW-1:0];
            iss_d     = iss_q + CW'(1);
          end
        end else begin
          issue = (iss_q > p_q);
          if (issue) begin
            mem_re    = 1'b1;
            mem_raddr = iss_m1[AW-1:0];
            rd_idx_d  = iss_m1[AW-1:0];
            iss_d     = iss_m1;
          end
        end
        rd_vld_d = issue;
        if (rd_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = full ? (rd_idx_q - AW'(1)) : (rd_idx_q + AW'(1));
          mem_wdata = rdata_q;
        end
        if (!rd_vld_q && !issue) begin
          state_d = S_INS;
        end
      end

      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = full ? AW'(p_q - CW'(1)) : p_q[AW-1:0];
        mem_wdata = '{start_cycle: s_q, end_cycle: e_q};
        if (!full) begin
          cnt_d = cnt_q + CW'(1);
        end
        res_d.status = ST_OK;
        state_d      = S_FIN;
      end

      S_FIN: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d = 1'b1;
          out_d     = res_q;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_NOP;
      s_q       <= '0;
      e_q       <= '0;
      b_q       <= '0;
      t_q       <= '0;
      c_q       <= '0;
      cnt_q     <= '0;
      iss_q     <= '0;
      p_q       <= '0;
      pfound_q  <= 1'b0;
      ovl_q     <= 1'b0;
      done_q    <= 1'b0;
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
      res_q     <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      s_q       <= s_d;
      e_q       <= e_d;
      b_q       <= b_d;
      t_q       <= t_d;
      c_q       <= c_d;
      cnt_q     <= cnt_d;
      iss_q     <= iss_d;
      p_q       <= p_d;
      pfound_q  <= pfound_d;
      ovl_q     <= ovl_d;
      done_q    <= done_d;
      rd_vld_q  <= rd_vld_d;
      rd_idx_q  <= rd_idx_d;
      res_q     <= res_d;
      out_vld_q <= out_vld_d;
      out_q     <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

  `IRT_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CW'(TABLE_ENTRIES), "entry count above table size")
  `IRT_ASSERT_IMP(a_no_rw_clash, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit same entry")
  `IRT_ASSERT_NXT(a_accept_next, req_i.valid && req_i.ready, state_q == S_SCAN || state_q == S_FIN, "bad state after accept")
  `IRT_ASSERT_NXT(a_ins_grow, state_q == S_INS && !full, cnt_q == $past(cnt_q) + CW'(1), "insert did not grow table")

endmodule
